/* hw/rtl/chfe_pkg.sv */
// Shared types and constants of the ccTalk host frame engine.
// No dependencies; every other file but the two interfaces refers to it by scoped names.
`default_nettype none

package chfe_pkg;

    // input item kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_LINE   = 2'd2;

    // result kinds
    localparam logic [1:0] RES_TX      = 2'd0;
    localparam logic [1:0] RES_PAYLOAD = 2'd1;
    localparam logic [1:0] RES_STATUS  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT       = 3'd1;
    localparam logic [2:0] ST_LENGTH      = 3'd2;
    localparam logic [2:0] ST_CHECKSUM    = 3'd3;
    localparam logic [2:0] ST_DEST        = 3'd4;
    localparam logic [2:0] ST_SOURCE      = 3'd5;
    localparam logic [2:0] ST_NOT_ACK     = 3'd6;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_CTRL_ADDR  = 2'd0;
    localparam logic [1:0] CFG_CRC16      = 2'd1;
    localparam logic [1:0] CFG_ENCRYPTION = 2'd2;

    // queue entry operations
    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_RX     = 2'd2;

    localparam logic [7:0] HOST_ADDRESS = 8'h01;
    localparam logic [8:0] MIN_FRAME    = 9'd5;
    localparam logic [8:0] COUNT_MAX    = 9'd511;
    localparam logic [7:0] CTRL_ADDR_RESET = 8'h01;

    typedef struct packed {
        logic [7:0] controller_address;
        logic       crc16_mode;
        logic       encryption_mode;
    } cfg_t;

    // one queue entry: everything the back end needs to emit the results of one item
    typedef struct packed {
        logic [1:0]      op;
        logic [3:0][7:0] bytes;
        logic [7:0]      chk;
        logic            with_chk;
        logic            with_pay;
        logic            with_stat;
        logic [2:0]      status;
        logic [31:0]     id;
    } desc_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic        last;
        logic [2:0]  status;
        logic [31:0] id;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/chfe_in_if.sv */
// Input channel of the ccTalk host frame engine: valid/ready plus one input word.
// No dependencies.
`default_nettype none

interface chfe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] device_address;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, kind, device_address, command_code, payload_length,
                    data_byte, frame_end, input ready);
    modport sink (input valid, kind, device_address, command_code, payload_length,
                  data_byte, frame_end, output ready);
endinterface

`default_nettype wire

/* hw/rtl/chfe_out_if.sv */
// Output channel of the ccTalk host frame engine: valid/ready plus one result word.
// No dependencies.
`default_nettype none

interface chfe_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  byte_value;
    logic        last_of_run;
    logic [2:0]  status;
    logic [31:0] request_number;

    modport source (output valid, result_kind, byte_value, last_of_run, status, request_number,
                    input ready);
    modport sink (input valid, result_kind, byte_value, last_of_run, status, request_number,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/chfe_front.sv */
// Front end: accepts input words, keeps transmit and receive frame state and
// pushes one queue entry per word that yields results. Uses chfe_pkg, chfe_in_if.
`default_nettype none

module chfe_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    chfe_in_if.sink             items,
    input  wire chfe_pkg::cfg_t cfg,
    input  wire logic           q_full,
    output logic                push,
    output chfe_pkg::desc_t     push_desc
);

    logic [7:0]      exp_src_reg, exp_src_next;
    logic [31:0]     req_cnt_reg, req_cnt_next;
    logic [7:0]      tx_sum_reg, tx_sum_next;
    logic [7:0]      tx_rem_reg, tx_rem_next;
    logic [8:0]      rx_cnt_reg, rx_cnt_next;
    logic [7:0]      rx_sum_reg, rx_sum_next;
    logic [3:0][7:0] hdr_reg, hdr_next;
    logic [7:0]      held_reg, held_next;

    logic            accept;
    logic [7:0]      hdr_sum;
    logic [7:0]      data_sum;
    logic [7:0]      rx_sum_new;
    logic [3:0][7:0] hdr_new;
    logic [8:0]      total;
    logic [8:0]      want_total;

    assign items.ready = !q_full;
    assign accept      = items.valid && items.ready;

    assign hdr_sum  = items.device_address + items.payload_length
                    + cfg.controller_address + items.command_code;
    assign data_sum = tx_sum_reg + items.data_byte;
    assign rx_sum_new = rx_sum_reg + items.data_byte;
    assign total = (rx_cnt_reg < chfe_pkg::COUNT_MAX) ? rx_cnt_reg + 9'd1 : chfe_pkg::COUNT_MAX;

    always_comb
    begin
        hdr_new = hdr_reg;
        if (rx_cnt_reg < 9'd4)
        begin
            hdr_new[rx_cnt_reg[1:0]] = items.data_byte;
        end
    end

    assign want_total = chfe_pkg::MIN_FRAME + {1'b0, hdr_new[1]};

    always_comb
    begin
        exp_src_next = exp_src_reg;
        req_cnt_next = req_cnt_reg;
        tx_sum_next  = tx_sum_reg;
        tx_rem_next  = tx_rem_reg;
        rx_cnt_next  = rx_cnt_reg;
        rx_sum_next  = rx_sum_reg;
        hdr_next     = hdr_reg;
        held_next    = held_reg;
        push         = 1'b0;
        push_desc    = '0;
        if (accept)
        begin
            case (items.kind)
                chfe_pkg::KIND_HEADER:
                begin
                    exp_src_next = items.device_address;
                    tx_sum_next  = 8'd0;
                    tx_rem_next  = 8'd0;
                    push         = 1'b1;
                    if (cfg.crc16_mode || cfg.encryption_mode)
                    begin
                        push_desc.op        = chfe_pkg::OP_RX;
                        push_desc.with_stat = 1'b1;
                        push_desc.status    = chfe_pkg::ST_UNSUPPORTED;
                    end
                    else
                    begin
                        req_cnt_next       = req_cnt_reg + 32'd1;
                        push_desc.op       = chfe_pkg::OP_HEADER;
                        push_desc.bytes[0] = items.device_address;
                        push_desc.bytes[1] = items.payload_length;
                        push_desc.bytes[2] = cfg.controller_address;
                        push_desc.bytes[3] = items.command_code;
                        push_desc.chk      = 8'd0 - hdr_sum;
                        push_desc.with_chk = (items.payload_length == 8'd0);
                        push_desc.id       = req_cnt_reg + 32'd1;
                        tx_sum_next        = hdr_sum;
                        tx_rem_next        = items.payload_length;
                    end
                end
                chfe_pkg::KIND_DATA:
                begin
                    // drop stray data with no frame open
                    if (tx_rem_reg != 8'd0)
                    begin
                        push               = 1'b1;
                        push_desc.op       = chfe_pkg::OP_DATA;
                        push_desc.bytes[0] = items.data_byte;
                        push_desc.chk      = 8'd0 - data_sum;
                        push_desc.with_chk = (tx_rem_reg == 8'd1);
                        tx_sum_next        = data_sum;
                        tx_rem_next        = tx_rem_reg - 8'd1;
                    end
                end
                chfe_pkg::KIND_LINE:
                begin
                    // payload runs one byte late so the checksum byte never leaves
                    push_desc.op       = chfe_pkg::OP_RX;
                    push_desc.bytes[0] = held_reg;
                    push_desc.with_pay = (rx_cnt_reg >= chfe_pkg::MIN_FRAME);
                    push_desc.with_stat = items.frame_end;
                    push = push_desc.with_pay || items.frame_end;
                    if (total < chfe_pkg::MIN_FRAME)
                        push_desc.status = chfe_pkg::ST_SHORT;
                    else if (total != want_total)
                        push_desc.status = chfe_pkg::ST_LENGTH;
                    else if (rx_sum_new != 8'd0)
                        push_desc.status = chfe_pkg::ST_CHECKSUM;
                    else if (hdr_new[0] != chfe_pkg::HOST_ADDRESS)
                        push_desc.status = chfe_pkg::ST_DEST;
                    else if (hdr_new[2] != exp_src_reg)
                        push_desc.status = chfe_pkg::ST_SOURCE;
                    else if (hdr_new[3] != 8'd0)
                        push_desc.status = chfe_pkg::ST_NOT_ACK;
                    else
                        push_desc.status = chfe_pkg::ST_OK;
                    if (items.frame_end)
                    begin
                        rx_cnt_next = 9'd0;
                        rx_sum_next = 8'd0;
                        hdr_next    = '0;
                        held_next   = 8'd0;
                    end
                    else
                    begin
                        rx_cnt_next = total;
                        rx_sum_next = rx_sum_new;
                        hdr_next    = hdr_new;
                        held_next   = items.data_byte;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_src_reg <= 8'd0;
            req_cnt_reg <= 32'd0;
            tx_sum_reg  <= 8'd0;
            tx_rem_reg  <= 8'd0;
            rx_cnt_reg  <= 9'd0;
            rx_sum_reg  <= 8'd0;
            hdr_reg     <= '0;
            held_reg    <= 8'd0;
        end
        else
        begin
            exp_src_reg <= exp_src_next;
            req_cnt_reg <= req_cnt_next;
            tx_sum_reg  <= tx_sum_next;
            tx_rem_reg  <= tx_rem_next;
            rx_cnt_reg  <= rx_cnt_next;
            rx_sum_reg  <= rx_sum_next;
            hdr_reg     <= hdr_next;
            held_reg    <= held_next;
        end
    end

`ifndef ASSERT_OFF
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("front pushed into a full queue");
    a_reject_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_desc.status == chfe_pkg::ST_UNSUPPORTED && push_desc.op == chfe_pkg::OP_RX
         && !push_desc.with_pay && items.kind == chfe_pkg::KIND_HEADER)
        |=> req_cnt_reg == $past(req_cnt_reg))
        else $error("rejected request advanced the request counter");
`endif

endmodule

`default_nettype wire

/* hw/rtl/chfe_queue.sv */
// Short queue of work entries between the front and back ends.
// Uses chfe_pkg for the entry type.
`default_nettype none

module chfe_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire chfe_pkg::desc_t push_desc,
    input  wire logic            pop,
    output chfe_pkg::desc_t      head,
    output logic                 empty,
    output logic                 full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    chfe_pkg::desc_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_CNT);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

/* hw/rtl/chfe_back.sv */
// Back end: walks the head queue entry one result per cycle, while the output is not stalled, into the output register.
// Uses chfe_pkg and chfe_out_if.
`default_nettype none

module chfe_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire chfe_pkg::desc_t head,
    input  wire logic            q_empty,
    output logic                 pop,
    chfe_out_if.source           results
);

    logic [2:0]        step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    chfe_pkg::result_t out_reg, out_next;
    chfe_pkg::result_t res;
    logic              last_step;
    logic              advance;

    always_comb
    begin
        res       = '0;
        last_step = 1'b1;
        case (head.op)
            chfe_pkg::OP_HEADER:
            begin
                res.kind = chfe_pkg::RES_TX;
                res.id   = head.id;
                if (step_reg < 3'd4)
                begin
                    res.value = head.bytes[step_reg[1:0]];
                    last_step = !head.with_chk && (step_reg == 3'd3);
                end
                else
                begin
                    res.value = head.chk;
                    res.last  = 1'b1;
                end
            end
            chfe_pkg::OP_DATA:
            begin
                res.kind = chfe_pkg::RES_TX;
                if (step_reg == 3'd0)
                begin
                    res.value = head.bytes[0];
                    last_step = !head.with_chk;
                end
                else
                begin
                    res.value = head.chk;
                    res.last  = 1'b1;
                end
            end
            chfe_pkg::OP_RX:
            begin
                if (head.with_pay && step_reg == 3'd0)
                begin
                    res.kind  = chfe_pkg::RES_PAYLOAD;
                    res.value = head.bytes[0];
                    last_step = !head.with_stat;
                end
                else
                begin
                    res.kind   = chfe_pkg::RES_STATUS;
                    res.last   = 1'b1;
                    res.status = head.status;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign advance = !q_empty && (!out_valid_reg || results.ready);
    assign pop     = advance && last_step;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
            step_next      = last_step ? 3'd0 : step_reg + 3'd1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign results.valid          = out_valid_reg;
    assign results.result_kind    = out_reg.kind;
    assign results.byte_value     = out_reg.value;
    assign results.last_of_run    = out_reg.last;
    assign results.status         = out_reg.status;
    assign results.request_number = out_reg.id;

`ifndef ASSERT_OFF
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= 3'd4)
        else $error("result step ran past the checksum byte");
    a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == chfe_pkg::RES_STATUS) |-> out_reg.last)
        else $error("status result without end mark");
`endif

endmodule

`default_nettype wire

/* hw/rtl/cctalk_host_frame_engine.sv */
// ccTalk host frame engine, 8-bit checksum variant. Takes one input word per cycle
// while its work queue (QUEUE_DEPTH entries) has room; words that yield no result leave
// nothing behind. The output side emits one result word per cycle while the receiver
// is ready, from a registered stage: a request header yields 4 results (5 with an empty
// payload, a single status word when rejected), a request data byte 1 or 2, a received
// line byte 0 to 2. Sustained throughput is therefore set by the back-end sequencer at one
// result per cycle. There is no clearing pass after reset. Configuration writes take
// effect at the next clock edge.
`default_nettype none

module cctalk_host_frame_engine #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    chfe_in_if.sink         items,
    chfe_out_if.source      results,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    chfe_pkg::cfg_t  cfg_reg, cfg_next;
    chfe_pkg::desc_t push_desc;
    chfe_pkg::desc_t head;
    logic            push;
    logic            pop;
    logic            q_empty;
    logic            q_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                chfe_pkg::CFG_CTRL_ADDR:  cfg_next.controller_address = cfg_data;
                chfe_pkg::CFG_CRC16:      cfg_next.crc16_mode         = cfg_data[0];
                chfe_pkg::CFG_ENCRYPTION: cfg_next.encryption_mode    = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.controller_address <= chfe_pkg::CTRL_ADDR_RESET;
            cfg_reg.crc16_mode         <= 1'b0;
            cfg_reg.encryption_mode    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    chfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    chfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    chfe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .results (results)
    );

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Testbench of the ccTalk host frame engine: drives request and line words with random
// gaps, predicts every result word and checks the output channel in order.
// Depends on chfe_pkg, chfe_in_if, chfe_out_if and cctalk_host_frame_engine.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] device_address;
        logic [7:0] command_code;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
        logic       frame_end;
    } host_word_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    chfe_in_if  items();
    chfe_out_if results();

    cctalk_host_frame_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow configuration and engine state
    logic [7:0]  ctrl_addr_q;
    logic        crc16_q;
    logic        des_q;
    logic [7:0]  reply_src;
    logic [31:0] request_count;
    logic [7:0]  tx_sum;
    logic [7:0]  tx_left;
    logic [8:0]  rx_count;
    logic [7:0]  rx_sum;
    logic [7:0]  rx_head [4];
    logic [7:0]  rx_held;

    chfe_pkg::result_t predicted_words [$];
    int      mismatches;
    int      idle_cycles;
    int      useful_words;
    bit      steady;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (steady || roll < 65)
            return 0;
        if (roll < 93)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    function void push_word(logic [1:0] kind, logic [7:0] value, logic last,
                            logic [2:0] status, logic [31:0] id);
        chfe_pkg::result_t r;
        r.kind   = kind;
        r.value  = value;
        r.last   = last;
        r.status = status;
        r.id     = id;
        predicted_words = {predicted_words, r};
    endfunction

    function void clear_rx();
        rx_count = '0;
        rx_sum   = '0;
        foreach (rx_head[i])
            rx_head[i] = '0;
        rx_held  = '0;
    endfunction

    function void predict_frame_words(host_word_t w);
        logic [8:0] pos;
        logic [2:0] verdict;
        case (w.kind)
            chfe_pkg::KIND_HEADER:
            begin
                reply_src = w.device_address;
                tx_left   = '0;
                tx_sum    = '0;
                if (crc16_q || des_q)
                    push_word(chfe_pkg::RES_STATUS, 8'd0, 1'b1, chfe_pkg::ST_UNSUPPORTED,
                              32'd0);
                else
                begin
                    request_count = request_count + 32'd1;
                    push_word(chfe_pkg::RES_TX, w.device_address, 1'b0, chfe_pkg::ST_OK,
                              request_count);
                    push_word(chfe_pkg::RES_TX, w.payload_length, 1'b0, chfe_pkg::ST_OK,
                              request_count);
                    push_word(chfe_pkg::RES_TX, ctrl_addr_q, 1'b0, chfe_pkg::ST_OK,
                              request_count);
                    push_word(chfe_pkg::RES_TX, w.command_code, 1'b0, chfe_pkg::ST_OK,
                              request_count);
                    tx_sum  = w.device_address + w.payload_length + ctrl_addr_q
                              + w.command_code;
                    tx_left = w.payload_length;
                    // empty request closes with its checksum right away
                    if (tx_left == 8'd0)
                        push_word(chfe_pkg::RES_TX, 8'd0 - tx_sum, 1'b1, chfe_pkg::ST_OK,
                                  request_count);
                end
            end
            chfe_pkg::KIND_DATA:
            begin
                if (tx_left != 8'd0)
                begin
                    push_word(chfe_pkg::RES_TX, w.data_byte, 1'b0, chfe_pkg::ST_OK, 32'd0);
                    tx_sum  = tx_sum + w.data_byte;
                    tx_left = tx_left - 8'd1;
                    if (tx_left == 8'd0)
                        push_word(chfe_pkg::RES_TX, 8'd0 - tx_sum, 1'b1, chfe_pkg::ST_OK,
                                  32'd0);
                end
            end
            chfe_pkg::KIND_LINE:
            begin
                pos = rx_count;
                if (pos < 9'd4)
                    rx_head[pos[1:0]] = w.data_byte;
                // payload leaves one byte late, so the checksum byte never does
                if (pos >= chfe_pkg::MIN_FRAME)
                    push_word(chfe_pkg::RES_PAYLOAD, rx_held, 1'b0, chfe_pkg::ST_OK, 32'd0);
                rx_held  = w.data_byte;
                rx_sum   = rx_sum + w.data_byte;
                rx_count = (pos < chfe_pkg::COUNT_MAX) ? pos + 9'd1 : chfe_pkg::COUNT_MAX;
                if (w.frame_end)
                begin
                    if (rx_count < chfe_pkg::MIN_FRAME)
                        verdict = chfe_pkg::ST_SHORT;
                    else if (rx_count != chfe_pkg::MIN_FRAME + {1'b0, rx_head[1]})
                        verdict = chfe_pkg::ST_LENGTH;
                    else if (rx_sum != 8'd0)
                        verdict = chfe_pkg::ST_CHECKSUM;
                    else if (rx_head[0] != chfe_pkg::HOST_ADDRESS)
                        verdict = chfe_pkg::ST_DEST;
                    else if (rx_head[2] != reply_src)
                        verdict = chfe_pkg::ST_SOURCE;
                    else if (rx_head[3] != 8'd0)
                        verdict = chfe_pkg::ST_NOT_ACK;
                    else
                        verdict = chfe_pkg::ST_OK;
                    push_word(chfe_pkg::RES_STATUS, 8'd0, 1'b1, verdict, 32'd0);
                    clear_rx();
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function void note_mismatch(string what, chfe_pkg::result_t want,
                                chfe_pkg::result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%s: expected kind %0d byte %02h last %0b status %0d id %0d,",
                     what, want.kind, want.value, want.last, want.status, want.id);
            $display("    got kind %0d byte %02h last %0b status %0d id %0d",
                     got.kind, got.value, got.last, got.status, got.id);
        end
    endfunction

    // output side: random back-pressure
    initial
    begin
        int stall;
        stall = 0;
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                results.ready <= 1'b0;
                stall--;
            end
            else
            begin
                results.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        chfe_pkg::result_t got;
        chfe_pkg::result_t want;
        if (rst_n)
        begin
            if ((items.valid && items.ready) || (results.valid && results.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (results.valid && results.ready)
            begin
                got.kind   = results.result_kind;
                got.value  = results.byte_value;
                got.last   = results.last_of_run;
                got.status = results.status;
                got.id     = results.request_number;
                if (predicted_words.size() == 0)
                    note_mismatch("result with none due", '0, got);
                else
                begin
                    want = predicted_words.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value
                        || got.last !== want.last || got.status !== want.status
                        || got.id !== want.id)
                        note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    task automatic send_word(logic [1:0] kind, logic [7:0] dev, logic [7:0] cmd,
                             logic [7:0] len, logic [7:0] data, logic fend);
        host_word_t w;
        int gap;
        w.kind           = kind;
        w.device_address = dev;
        w.command_code   = cmd;
        w.payload_length = len;
        w.data_byte      = data;
        w.frame_end      = fend;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            items.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        items.valid          <= 1'b1;
        items.kind           <= w.kind;
        items.device_address <= w.device_address;
        items.command_code   <= w.command_code;
        items.payload_length <= w.payload_length;
        items.data_byte      <= w.data_byte;
        items.frame_end      <= w.frame_end;
        do
            @(posedge clk);
        while (!items.ready);
        if (!(kind == KIND_UNUSED || (kind == chfe_pkg::KIND_DATA && tx_left == 8'd0)))
            useful_words++;
        predict_frame_words(w);
    endtask

    task automatic send_data(logic [7:0] data);
        send_word(chfe_pkg::KIND_DATA, 8'($urandom), 8'($urandom), 8'($urandom), data,
                  1'($urandom));
    endtask

    task automatic send_line(logic [7:0] data, logic fend);
        send_word(chfe_pkg::KIND_LINE, 8'($urandom), 8'($urandom), 8'($urandom), data, fend);
    endtask

    // response frame with random payload; sum_error spoils the checksum byte
    task automatic send_response(logic [7:0] dest, logic [7:0] len_field, logic [7:0] src,
                                 logic [7:0] cmd, int body_len, logic [7:0] sum_error);
        logic [7:0] total;
        logic [7:0] b;
        total = dest + len_field + src + cmd;
        send_line(dest, 1'b0);
        send_line(len_field, 1'b0);
        send_line(src, 1'b0);
        send_line(cmd, 1'b0);
        repeat (body_len)
        begin
            b = 8'($urandom);
            total = total + b;
            send_line(b, 1'b0);
        end
        send_line((8'd0 - total) ^ sum_error, 1'b1);
    endtask

    // drain the engine before touching a register
    task automatic write_reg(logic [1:0] index, logic [7:0] value);
        @(negedge clk);
        items.valid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            chfe_pkg::CFG_CTRL_ADDR:  ctrl_addr_q = value;
            chfe_pkg::CFG_CRC16:      crc16_q = value[0];
            chfe_pkg::CFG_ENCRYPTION: des_q = value[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic test_request_frames();
        send_word(chfe_pkg::KIND_HEADER, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
        send_word(chfe_pkg::KIND_HEADER, 8'h00, 8'hFF, 8'h02, 8'hFF, 1'b1);
        send_data(8'h00);
        send_data(8'hFF);
        // nothing pending: drop
        send_data(8'h5A);
        send_word(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // long request, abandoned by the next header
        send_word(chfe_pkg::KIND_HEADER, 8'h3C, 8'h12, 8'hFF, 8'h00, 1'b0);
        send_data(8'h81);
        send_data(8'h7E);
        send_word(chfe_pkg::KIND_HEADER, 8'hC3, 8'h80, 8'h01, 8'h00, 1'b0);
        send_data(8'h01);
    endtask

    task automatic test_response_checks();
        send_response(chfe_pkg::HOST_ADDRESS, 8'd0, reply_src, 8'h00, 0, 8'h00);
        send_response(chfe_pkg::HOST_ADDRESS, 8'd2, reply_src, 8'h00, 2, 8'h00);
        send_line(chfe_pkg::HOST_ADDRESS, 1'b0);
        send_line(8'hFF, 1'b1);
        send_response(chfe_pkg::HOST_ADDRESS, 8'd1, reply_src, 8'h00, 0, 8'h00);
        send_response(chfe_pkg::HOST_ADDRESS, 8'd0, reply_src, 8'h00, 0, 8'h80);
        send_response(8'hFE, 8'd0, reply_src, 8'h00, 0, 8'h00);
        send_response(chfe_pkg::HOST_ADDRESS, 8'd0, ~reply_src, 8'h00, 0, 8'h00);
        send_response(chfe_pkg::HOST_ADDRESS, 8'd0, reply_src, 8'hFF, 0, 8'h00);
        // several faults at once: the earliest check wins
        send_response(8'h00, 8'd3, ~reply_src, 8'h05, 1, 8'h01);
    endtask

    // 512 line bytes: the count must stop at its top, not wrap
    task automatic test_long_response();
        send_response(chfe_pkg::HOST_ADDRESS, 8'hFF, reply_src, 8'h00, 507, 8'h00);
    endtask

    task automatic test_config_phases();
        write_reg(chfe_pkg::CFG_CTRL_ADDR, 8'h00);
        send_word(chfe_pkg::KIND_HEADER, 8'h5A, 8'h33, 8'h00, 8'h00, 1'b0);
        write_reg(chfe_pkg::CFG_CTRL_ADDR, 8'hFF);
        send_word(chfe_pkg::KIND_HEADER, 8'hA5, 8'h0F, 8'h01, 8'h00, 1'b0);
        send_data(8'hFF);
        // a pending frame is dropped by a rejected header
        send_word(chfe_pkg::KIND_HEADER, 8'h21, 8'h44, 8'h03, 8'h00, 1'b0);
        send_data(8'h10);
        write_reg(chfe_pkg::CFG_CRC16, 8'd1);
        send_word(chfe_pkg::KIND_HEADER, 8'h42, 8'h01, 8'h02, 8'h00, 1'b0);
        send_data(8'h11);
        send_response(chfe_pkg::HOST_ADDRESS, 8'd0, 8'h42, 8'h00, 0, 8'h00);
        write_reg(chfe_pkg::CFG_CRC16, 8'd0);
        write_reg(chfe_pkg::CFG_ENCRYPTION, 8'd1);
        send_word(chfe_pkg::KIND_HEADER, 8'h17, 8'h02, 8'h00, 8'h00, 1'b0);
        write_reg(chfe_pkg::CFG_CRC16, 8'd1);
        send_word(chfe_pkg::KIND_HEADER, 8'h18, 8'h03, 8'h01, 8'h00, 1'b0);
        write_reg(chfe_pkg::CFG_CRC16, 8'd0);
        write_reg(chfe_pkg::CFG_ENCRYPTION, 8'd0);
        write_reg(chfe_pkg::CFG_CTRL_ADDR, chfe_pkg::CTRL_ADDR_RESET);
        send_word(chfe_pkg::KIND_HEADER, 8'h19, 8'h04, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic random_sequence();
        int roll;
        int count;
        logic [7:0] len;
        logic [7:0] dest;
        logic [7:0] src;
        logic [7:0] cmd;
        logic [7:0] err;
        roll = int'($urandom_range(0, 99));
        if (roll < 40)
        begin
            len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 24))
                                              : 8'($urandom_range(0, 6));
            send_word(chfe_pkg::KIND_HEADER, 8'($urandom), 8'($urandom), len, 8'($urandom),
                      1'($urandom));
            count = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, len)) : int'(len);
            repeat (count) send_data(8'($urandom));
        end
        else if (roll < 85)
        begin
            dest  = chfe_pkg::HOST_ADDRESS;
            src   = reply_src;
            cmd   = 8'h00;
            err   = 8'h00;
            count = int'($urandom_range(0, 6));
            len   = 8'(count);
            case ($urandom_range(0, 11))
                6:  err  = 8'($urandom_range(1, 255));
                7:  dest = chfe_pkg::HOST_ADDRESS ^ 8'($urandom_range(1, 255));
                8:  src  = reply_src ^ 8'($urandom_range(1, 255));
                9:  cmd  = 8'($urandom_range(1, 255));
                10: len  = len ^ 8'($urandom_range(1, 255));
                default:
                begin
                end
            endcase
            send_response(dest, len, src, cmd, count, err);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: send_data(8'($urandom));
                1: send_word(KIND_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 1'($urandom));
                2:
                begin
                    count = int'($urandom_range(1, 4));
                    for (int i = 0; i < count; i++)
                        send_line(8'($urandom), i == count - 1);
                end
                default: send_line(8'($urandom), $urandom_range(0, 3) == 0);
            endcase
        end
    endtask

    task automatic test_random_traffic(int goal);
        int base;
        base = useful_words;
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            if (chunk > 0)
                write_reg(chfe_pkg::CFG_CTRL_ADDR, 8'($urandom));
            steady = (chunk == 2);
            while (useful_words < base + goal * (chunk + 1) / 4)
                random_sequence();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = chfe_pkg::CFG_CTRL_ADDR;
        cfg_data             = 8'h00;
        items.valid          = 1'b0;
        items.kind           = chfe_pkg::KIND_HEADER;
        items.device_address = 8'h00;
        items.command_code   = 8'h00;
        items.payload_length = 8'h00;
        items.data_byte      = 8'h00;
        items.frame_end      = 1'b0;
        steady               = 1'b0;
        mismatches           = 0;
        useful_words         = 0;
        ctrl_addr_q          = chfe_pkg::CTRL_ADDR_RESET;
        crc16_q              = 1'b0;
        des_q                = 1'b0;
        reply_src            = 8'h00;
        request_count        = 32'd0;
        tx_sum               = 8'h00;
        tx_left              = 8'h00;
        clear_rx();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_request_frames();
        test_response_checks();
        test_long_response();
        test_config_phases();
        test_random_traffic(100);

        @(negedge clk);
        items.valid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && predicted_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/chfe_pkg.sv
hw/rtl/chfe_in_if.sv
hw/rtl/chfe_out_if.sv
hw/rtl/chfe_front.sv
hw/rtl/chfe_queue.sv
hw/rtl/chfe_back.sv
hw/rtl/cctalk_host_frame_engine.sv
bench/testbench.sv
